// ===== rtl/core/multi_stack_block_mover_defines.svh =====
// Assertion macros for the multi stack block mover.
// Used by the top level; expects clk and rst_n in scope where expanded.
`ifndef MULTI_STACK_BLOCK_MOVER_DEFINES_SVH
`define MULTI_STACK_BLOCK_MOVER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MSBM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define MSBM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/msbm_pkg.sv =====
// Shared types and constants for the multi stack block mover.
// No dependencies; used by every module of the block.
package msbm_pkg;

    // Default sizes
    localparam int NUM_STACKS_DEF  = 16;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int MAX_RESULTS     = 16;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int STACK_W = 4;
    localparam int VALUE_W = 8;
    localparam int COUNT_W = 7;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Configuration port
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] REG_KEEP_ORDER = 2'd0;

    // Input item kinds
    localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MOVE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

    // Result kinds
    localparam logic RES_TOP   = 1'b0;
    localparam logic RES_ERROR = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [STACK_W-1:0] push_stack;
        logic [VALUE_W-1:0] push_value;
        logic [COUNT_W-1:0] move_count;
        logic [STACK_W-1:0] from_stack;
        logic [STACK_W-1:0] to_stack;
    } item_t;

    typedef struct packed {
        logic               result_kind;
        logic [STACK_W-1:0] stack_index;
        logic [VALUE_W-1:0] top_value;
        logic               is_empty;
        logic               last;
    } result_t;

    // Classified operation handed to the back end
    typedef enum logic [1:0] {
        OP_PUSH,
        OP_MOVE,
        OP_REPORT,
        OP_ERROR
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [STACK_W-1:0] stack_a;   // push target or move source
        logic [STACK_W-1:0] stack_b;   // move destination
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
    } cmd_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_PUSH_CHK,
        BK_MOVE_CHK,
        BK_MOVE_COPY,
        BK_MOVE_END,
        BK_REP_H,
        BK_REP_M,
        BK_REP_OUT,
        BK_ERR_OUT
    } back_state_t;

endpackage

// ===== rtl/core/msbm_front.sv =====
// Front end: accepts input items, range checks them and turns them into commands.
// Depends on msbm_pkg; feeds msbm_queue.
module msbm_front #(
    parameter int NUM_STACKS = msbm_pkg::NUM_STACKS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  msbm_pkg::item_t  item,
    input  msbm_pkg::q_stat_t q_stat,
    output logic             q_push,
    output msbm_pkg::cmd_t   q_data
);

    logic            fv_reg;
    logic            fv_next;
    msbm_pkg::cmd_t  fcmd_reg;
    msbm_pkg::cmd_t  fcmd_next;
    msbm_pkg::cmd_t  cls_cmd;
    logic            cls_keep;
    logic            accept;
    logic            push_ok;
    logic            from_ok;
    logic            to_ok;

    // Hand the held command on whenever the queue has room
    assign q_push     = fv_reg && !q_stat.full;
    assign q_data     = fcmd_reg;
    assign item_ready = !fv_reg || !q_stat.full;
    assign accept     = item_valid && item_ready;

    assign push_ok = int'(item.push_stack) < NUM_STACKS;
    assign from_ok = int'(item.from_stack) < NUM_STACKS;
    assign to_ok   = int'(item.to_stack) < NUM_STACKS;

    // Classification; spare kinds and zero-count moves between valid stacks are dropped here
    always_comb
    begin
        cls_cmd.op      = msbm_pkg::OP_ERROR;
        cls_cmd.stack_a = item.from_stack;
        cls_cmd.stack_b = item.to_stack;
        cls_cmd.value   = item.push_value;
        cls_cmd.count   = item.move_count;
        cls_keep        = 1'b0;
        case (item.kind)
            msbm_pkg::KIND_PUSH:
            begin
                cls_cmd.stack_a = item.push_stack;
                cls_cmd.op      = push_ok ? msbm_pkg::OP_PUSH : msbm_pkg::OP_ERROR;
                cls_keep        = 1'b1;
            end
            msbm_pkg::KIND_MOVE:
            begin
                if (!from_ok || !to_ok)
                begin
                    cls_cmd.op = msbm_pkg::OP_ERROR;
                    cls_keep   = 1'b1;
                end
                else
                begin
                    cls_cmd.op = msbm_pkg::OP_MOVE;
                    cls_keep   = (item.move_count != '0);
                end
            end
            msbm_pkg::KIND_REPORT:
            begin
                cls_cmd.op = msbm_pkg::OP_REPORT;
                cls_keep   = 1'b1;
            end
            default:
            begin
                cls_keep = 1'b0;
            end
        endcase
    end

    // Holding register update
    always_comb
    begin
        fv_next   = fv_reg && !q_push;
        fcmd_next = fcmd_reg;
        if (accept)
        begin
            fv_next   = cls_keep;
            fcmd_next = cls_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fcmd_reg <= fcmd_next;
    end

endmodule

// ===== rtl/core/msbm_queue.sv =====
// Short command FIFO between front and back end.
// Depends on msbm_pkg.
module msbm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  msbm_pkg::cmd_t    push_data,
    input  logic              pop,
    output msbm_pkg::cmd_t    pop_data,
    output msbm_pkg::q_stat_t stat
);

    msbm_pkg::cmd_t                q_mem [msbm_pkg::QUEUE_DEPTH];
    logic [msbm_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [msbm_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [msbm_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [msbm_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [msbm_pkg::QCNT_W-1:0]   count_reg;
    logic [msbm_pkg::QCNT_W-1:0]   count_next;

    assign pop_data   = q_mem[rd_ptr_reg];
    assign stat.full  = (count_reg == msbm_pkg::QCNT_W'(msbm_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/msbm_back.sv =====
// Back end: stack store, height table and the sequencer that runs commands.
// Depends on msbm_pkg; takes commands from msbm_queue, drives the result port.
module msbm_back #(
    parameter int NUM_STACKS  = msbm_pkg::NUM_STACKS_DEF,
    parameter int STACK_DEPTH = msbm_pkg::STACK_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              keep_order,
    input  logic              cmd_valid,
    input  msbm_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    output logic              result_valid,
    input  logic              result_ready,
    output msbm_pkg::result_t result
);

    localparam int SW        = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int HW        = $clog2(STACK_DEPTH + 1);
    localparam int CW        = ((HW > msbm_pkg::COUNT_W) ? HW : msbm_pkg::COUNT_W) + 1;
    localparam int MEM_DEPTH = NUM_STACKS * STACK_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int REP_COUNT = (NUM_STACKS < msbm_pkg::MAX_RESULTS) ?
                               NUM_STACKS : msbm_pkg::MAX_RESULTS;
    localparam logic [msbm_pkg::STACK_W-1:0] REP_LAST = msbm_pkg::STACK_W'(REP_COUNT - 1);

    // Memories
    logic [msbm_pkg::VALUE_W-1:0] store_mem  [MEM_DEPTH];
    logic [HW-1:0]                height_mem [NUM_STACKS];
    logic [NUM_STACKS-1:0]        hvalid_reg;

    // Sequencer state
    msbm_pkg::back_state_t        state_reg;
    msbm_pkg::back_state_t        state_next;
    msbm_pkg::cmd_t               cmd_reg;
    msbm_pkg::cmd_t               cmd_next;
    logic [msbm_pkg::STACK_W-1:0] rep_idx_reg;
    logic [msbm_pkg::STACK_W-1:0] rep_idx_next;
    logic [AW-1:0]                rd_addr_reg;
    logic [AW-1:0]                rd_addr_next;
    logic [AW-1:0]                wr_addr_reg;
    logic [AW-1:0]                wr_addr_next;
    logic [HW-1:0]                cnt_reg;
    logic [HW-1:0]                cnt_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    msbm_pkg::result_t            out_data_reg;
    msbm_pkg::result_t            out_data_next;

    // Registered read data
    logic [HW-1:0]                ha_rd_reg;
    logic [HW-1:0]                hb_rd_reg;
    logic                         hva_rd_reg;
    logic                         hvb_rd_reg;
    logic [msbm_pkg::VALUE_W-1:0] store_rd_reg;

    // Memory controls
    logic                         h_rd_en;
    logic [SW-1:0]                ha_addr;
    logic [SW-1:0]                hb_addr;
    logic                         h_wr_en;
    logic [SW-1:0]                h_wr_addr;
    logic [HW-1:0]                h_wr_data;
    logic                         s_rd_en;
    logic [AW-1:0]                s_rd_addr;
    logic                         s_wr_en;
    logic [AW-1:0]                s_wr_addr;
    logic [msbm_pkg::VALUE_W-1:0] s_wr_data;
    logic                         out_load;
    msbm_pkg::result_t            out_load_data;

    // Derived values
    logic [HW-1:0]                h_src;
    logic [HW-1:0]                h_dst;
    logic [HW-1:0]                n_hw;
    logic [CW-1:0]                n_ext;
    logic [SW-1:0]                src_idx;
    logic [SW-1:0]                dst_idx;
    logic [SW-1:0]                rep_sidx;
    logic [AW-1:0]                src_base;
    logic [AW-1:0]                dst_base;
    logic [AW-1:0]                rep_base;
    logic                         out_free;
    logic                         push_full;
    logic                         move_short;
    logic                         move_same;
    logic                         move_over;
    logic                         cnt_last;
    logic                         rep_empty;
    logic                         rep_last;

    // Heights never written read as zero
    assign h_src    = hva_rd_reg ? ha_rd_reg : '0;
    assign h_dst    = hvb_rd_reg ? hb_rd_reg : '0;
    assign n_hw     = HW'(cmd_reg.count);
    assign n_ext    = CW'(cmd_reg.count);
    assign src_idx  = SW'(cmd_reg.stack_a);
    assign dst_idx  = SW'(cmd_reg.stack_b);
    assign rep_sidx = SW'(rep_idx_reg);
    assign src_base = AW'(STACK_DEPTH * src_idx);
    assign dst_base = AW'(STACK_DEPTH * dst_idx);
    assign rep_base = AW'(STACK_DEPTH * rep_sidx);

    assign out_free   = !out_valid_reg || result_ready;
    assign push_full  = (h_src >= HW'(STACK_DEPTH));
    assign move_short = (n_ext > CW'(h_src));
    assign move_same  = (cmd_reg.stack_a == cmd_reg.stack_b);
    assign move_over  = ((CW'(h_dst) + n_ext) > CW'(STACK_DEPTH));
    assign cnt_last   = (cnt_reg == (n_hw - 1'b1));
    assign rep_empty  = (h_src == '0);
    assign rep_last   = (rep_idx_reg == REP_LAST);

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msbm_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        msbm_pkg::OP_PUSH:   state_next = msbm_pkg::BK_PUSH_CHK;
                        msbm_pkg::OP_MOVE:   state_next = msbm_pkg::BK_MOVE_CHK;
                        msbm_pkg::OP_REPORT: state_next = msbm_pkg::BK_REP_H;
                        default:             state_next = msbm_pkg::BK_ERR_OUT;
                    endcase
                end
            end
            msbm_pkg::BK_PUSH_CHK:
            begin
                state_next = push_full ? msbm_pkg::BK_ERR_OUT : msbm_pkg::BK_IDLE;
            end
            msbm_pkg::BK_MOVE_CHK:
            begin
                if (move_short)
                begin
                    state_next = msbm_pkg::BK_ERR_OUT;
                end
                else if (move_same)
                begin
                    state_next = msbm_pkg::BK_IDLE;
                end
                else if (move_over)
                begin
                    state_next = msbm_pkg::BK_ERR_OUT;
                end
                else
                begin
                    state_next = msbm_pkg::BK_MOVE_COPY;
                end
            end
            msbm_pkg::BK_MOVE_COPY:
            begin
                if (cnt_last)
                begin
                    state_next = msbm_pkg::BK_MOVE_END;
                end
            end
            msbm_pkg::BK_MOVE_END:
            begin
                state_next = msbm_pkg::BK_IDLE;
            end
            msbm_pkg::BK_REP_H:
            begin
                state_next = msbm_pkg::BK_REP_M;
            end
            msbm_pkg::BK_REP_M:
            begin
                state_next = msbm_pkg::BK_REP_OUT;
            end
            msbm_pkg::BK_REP_OUT:
            begin
                if (out_free)
                begin
                    state_next = rep_last ? msbm_pkg::BK_IDLE : msbm_pkg::BK_REP_H;
                end
            end
            msbm_pkg::BK_ERR_OUT:
            begin
                if (out_free)
                begin
                    state_next = msbm_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = msbm_pkg::BK_IDLE;
            end
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        cmd_pop       = 1'b0;
        cmd_next      = cmd_reg;
        rep_idx_next  = rep_idx_reg;
        rd_addr_next  = rd_addr_reg;
        wr_addr_next  = wr_addr_reg;
        cnt_next      = cnt_reg;
        h_rd_en       = 1'b0;
        ha_addr       = SW'(cmd.stack_a);
        hb_addr       = SW'(cmd.stack_b);
        h_wr_en       = 1'b0;
        h_wr_addr     = src_idx;
        h_wr_data     = h_src + 1'b1;
        s_rd_en       = 1'b0;
        s_rd_addr     = rd_addr_reg;
        s_wr_en       = 1'b0;
        s_wr_addr     = wr_addr_reg;
        s_wr_data     = store_rd_reg;
        out_load      = 1'b0;
        out_load_data = out_data_reg;
        case (state_reg)
            msbm_pkg::BK_IDLE:
            begin
                // Take a command and fetch both heights it may need
                if (cmd_valid)
                begin
                    cmd_pop      = 1'b1;
                    cmd_next     = cmd;
                    h_rd_en      = 1'b1;
                    rep_idx_next = '0;
                end
            end
            msbm_pkg::BK_PUSH_CHK:
            begin
                if (!push_full)
                begin
                    s_wr_en   = 1'b1;
                    s_wr_addr = src_base + AW'(h_src);
                    s_wr_data = cmd_reg.value;
                    h_wr_en   = 1'b1;
                    h_wr_addr = src_idx;
                    h_wr_data = h_src + 1'b1;
                end
            end
            msbm_pkg::BK_MOVE_CHK:
            begin
                // Source height drops now; destination set at the end
                if (!move_short && !move_same && !move_over)
                begin
                    h_wr_en      = 1'b1;
                    h_wr_addr    = src_idx;
                    h_wr_data    = h_src - n_hw;
                    rd_addr_next = src_base +
                                   AW'(keep_order ? (h_src - n_hw) : (h_src - 1'b1));
                    wr_addr_next = dst_base + AW'(h_dst);
                    cnt_next     = '0;
                end
            end
            msbm_pkg::BK_MOVE_COPY:
            begin
                // Read one value a cycle, write it in the next cycle
                s_rd_en      = 1'b1;
                s_rd_addr    = rd_addr_reg;
                rd_addr_next = keep_order ? rd_addr_reg + 1'b1 : rd_addr_reg - 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg != '0)
                begin
                    s_wr_en      = 1'b1;
                    s_wr_addr    = wr_addr_reg;
                    s_wr_data    = store_rd_reg;
                    wr_addr_next = wr_addr_reg + 1'b1;
                end
            end
            msbm_pkg::BK_MOVE_END:
            begin
                s_wr_en   = 1'b1;
                s_wr_addr = wr_addr_reg;
                s_wr_data = store_rd_reg;
                h_wr_en   = 1'b1;
                h_wr_addr = dst_idx;
                h_wr_data = h_dst + n_hw;
            end
            msbm_pkg::BK_REP_H:
            begin
                h_rd_en = 1'b1;
                ha_addr = rep_sidx;
            end
            msbm_pkg::BK_REP_M:
            begin
                if (!rep_empty)
                begin
                    s_rd_en   = 1'b1;
                    s_rd_addr = rep_base + AW'(h_src - 1'b1);
                end
            end
            msbm_pkg::BK_REP_OUT:
            begin
                if (out_free)
                begin
                    out_load                  = 1'b1;
                    out_load_data.result_kind = msbm_pkg::RES_TOP;
                    out_load_data.stack_index = rep_idx_reg;
                    out_load_data.top_value   = rep_empty ? '0 : store_rd_reg;
                    out_load_data.is_empty    = rep_empty;
                    out_load_data.last        = rep_last;
                    rep_idx_next              = rep_idx_reg + 1'b1;
                end
            end
            msbm_pkg::BK_ERR_OUT:
            begin
                if (out_free)
                begin
                    out_load                  = 1'b1;
                    out_load_data.result_kind = msbm_pkg::RES_ERROR;
                    out_load_data.stack_index = '0;
                    out_load_data.top_value   = '0;
                    out_load_data.is_empty    = 1'b0;
                    out_load_data.last        = 1'b1;
                end
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    // Output register: loads when empty or while the previous result is being taken
    always_comb
    begin
        out_valid_next = out_valid_reg && !result_ready;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = out_load_data;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msbm_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            hvalid_reg    <= '0;
            rep_idx_reg   <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rep_idx_reg   <= rep_idx_next;
            cnt_reg       <= cnt_next;
            if (h_wr_en)
            begin
                hvalid_reg[h_wr_addr] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        rd_addr_reg  <= rd_addr_next;
        wr_addr_reg  <= wr_addr_next;
        out_data_reg <= out_data_next;
    end

    // Height table: two read ports, one write port
    always_ff @(posedge clk)
    begin
        if (h_rd_en)
        begin
            ha_rd_reg  <= height_mem[ha_addr];
            hb_rd_reg  <= height_mem[hb_addr];
            hva_rd_reg <= hvalid_reg[ha_addr];
            hvb_rd_reg <= hvalid_reg[hb_addr];
        end
        if (h_wr_en)
        begin
            height_mem[h_wr_addr] <= h_wr_data;
        end
    end

    // Stack store: one read port, one write port
    always_ff @(posedge clk)
    begin
        if (s_rd_en)
        begin
            store_rd_reg <= store_mem[s_rd_addr];
        end
        if (s_wr_en)
        begin
            store_mem[s_wr_addr] <= s_wr_data;
        end
    end

endmodule

// ===== rtl/core/multi_stack_block_mover.sv =====
// Results: a report gives one result per stack (up to 16 stacks); an error gives one error result.
// Flow: the back end runs one command at a time and is held by result stalls; the front
// accepts while the queue has room.
// Reset: heights read as zero at once (per-stack valid bits), store contents are left
// undefined, keep_order clears to 0; no clearing pass, items accepted right after reset.
module multi_stack_block_mover #(
    parameter int NUM_STACKS  = msbm_pkg::NUM_STACKS_DEF,
    parameter int STACK_DEPTH = msbm_pkg::STACK_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  msbm_pkg::item_t               item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output msbm_pkg::result_t             result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msbm_pkg::PADDR_W-1:0]  paddr,
    input  logic [msbm_pkg::PDATA_W-1:0]  pwdata,
    output logic [msbm_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

`include "multi_stack_block_mover_defines.svh"

    logic              keep_order_reg;
    logic              keep_order_next;
    logic              cfg_write;
    logic              q_push;
    logic              q_pop;
    msbm_pkg::cmd_t    q_wdata;
    msbm_pkg::cmd_t    q_rdata;
    msbm_pkg::q_stat_t q_stat;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr == msbm_pkg::REG_KEEP_ORDER);
    assign prdata    = (paddr == msbm_pkg::REG_KEEP_ORDER) ?
                       msbm_pkg::PDATA_W'(keep_order_reg) : '0;

    always_comb
    begin
        keep_order_next = cfg_write ? pwdata[0] : keep_order_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_order_reg <= 1'b0;
        end
        else
        begin
            keep_order_reg <= keep_order_next;
        end
    end

    msbm_front #(
        .NUM_STACKS (NUM_STACKS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    msbm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .stat      (q_stat)
    );

    msbm_back #(
        .NUM_STACKS  (NUM_STACKS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .keep_order   (keep_order_reg),
        .cmd_valid    (!q_stat.empty),
        .cmd          (q_rdata),
        .cmd_pop      (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Checks
    `MSBM_ASSERT_IMP(a_queue_no_overflow, q_push, !q_stat.full, "command queue written when full")
    `MSBM_ASSERT_IMP(a_queue_no_underflow, q_pop, !q_stat.empty, "command queue read when empty")
    `MSBM_ASSERT_NXT(a_queue_count, q_push && !q_pop, q_stat.count == msbm_pkg::QCNT_W'($past(q_stat.count) + 1'b1), "queue fill count did not advance")
    `MSBM_ASSERT_IMP(a_error_shape, result_valid && (result.result_kind == msbm_pkg::RES_ERROR), result.last && !result.is_empty && (result.top_value == 8'd0) && (result.stack_index == 4'd0), "malformed error result")

endmodule

// ===== tb/sv/multi_stack_block_mover_tb.sv =====
// Self-checking testbench for multi_stack_block_mover: stacks, pushes, moves, reports.
// Depends on msbm_pkg (item and result types, kind codes, register address) and the RTL.
// A directed stimulus table is followed by random traffic, all checked by a stack predictor.
`timescale 1ns / 1ps

module multi_stack_block_mover_tb;

    typedef msbm_pkg::item_t   item_t;
    typedef msbm_pkg::result_t result_t;

    localparam int NUM_STACKS   = msbm_pkg::NUM_STACKS_DEF;
    localparam int STACK_DEPTH  = msbm_pkg::STACK_DEPTH_DEF;
    localparam int REPORT_COUNT = (NUM_STACKS < msbm_pkg::MAX_RESULTS) ?
                                  NUM_STACKS : msbm_pkg::MAX_RESULTS;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_CYCLES = 500;    // a full queue of 64-value moves, with margin
    localparam int HOLD_CYCLES  = 500;
    localparam int PHASE_ITEMS  = 112;
    localparam int DIR_ROWS     = 23;

    localparam int KIND_W  = msbm_pkg::KIND_W;
    localparam int STACK_W = msbm_pkg::STACK_W;
    localparam int VALUE_W = msbm_pkg::VALUE_W;
    localparam int COUNT_W = msbm_pkg::COUNT_W;
    localparam int PADDR_W = msbm_pkg::PADDR_W;
    localparam int PDATA_W = msbm_pkg::PDATA_W;

    localparam logic [KIND_W-1:0]  KIND_PUSH      = msbm_pkg::KIND_PUSH;
    localparam logic [KIND_W-1:0]  KIND_MOVE      = msbm_pkg::KIND_MOVE;
    localparam logic [KIND_W-1:0]  KIND_REPORT    = msbm_pkg::KIND_REPORT;
    localparam logic               RES_TOP        = msbm_pkg::RES_TOP;
    localparam logic               RES_ERROR      = msbm_pkg::RES_ERROR;
    localparam logic [PADDR_W-1:0] REG_KEEP_ORDER = msbm_pkg::REG_KEEP_ORDER;

    // Spare kind code: the block ignores it
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    // How a directed row is checked
    typedef enum logic [1:0] {
        CHECK_MODEL,
        CHECK_SILENT,
        CHECK_REJECT,
        CHECK_ALL_EMPTY
    } row_check_t;

    typedef struct packed {
        item_t      it;
        row_check_t chk;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_ready;
    item_t               item;
    logic                result_valid;
    logic                result_ready;
    result_t             result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Predictor state
    int                  pile_height [NUM_STACKS];
    logic [VALUE_W-1:0]  pile_bytes [NUM_STACKS][STACK_DEPTH];
    logic                order_kept;
    result_t             stack_answers[$];
    result_t             pending_results[$];

    stim_row_t           directed_rows [DIR_ROWS];

    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  hold_requests;
    int                  mismatch_count;
    int                  cycle_count;
    int                  results_checked;
    int                  rejects_seen;
    int                  pushes_sent;
    int                  moves_sent;
    int                  reports_sent;
    int                  spares_sent;

    multi_stack_block_mover dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timed out after %0d cycles", $time, cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic result_t rejection();
        result_t r;
        r.result_kind = RES_ERROR;
        r.stack_index = '0;
        r.top_value   = '0;
        r.is_empty    = 1'b0;
        r.last        = 1'b1;
        return r;
    endfunction

    // Works out the results of one accepted item and updates the stacks
    task automatic apply_to_stacks(input item_t it);
        int      hs;
        int      hd;
        int      n;
        int      k;
        result_t r;
        stack_answers.delete();
        case (it.kind)
            KIND_PUSH:
            begin
                if (pile_height[it.push_stack] >= STACK_DEPTH)
                    stack_answers = {stack_answers, rejection()};
                else
                begin
                    pile_bytes[it.push_stack][pile_height[it.push_stack]] = it.push_value;
                    pile_height[it.push_stack]++;
                end
            end
            KIND_MOVE:
            begin
                hs = pile_height[it.from_stack];
                hd = pile_height[it.to_stack];
                n  = int'(it.move_count);
                if (n > hs)
                    stack_answers = {stack_answers, rejection()};
                else if (n != 0 && it.from_stack != it.to_stack)
                begin
                    if (hd + n > STACK_DEPTH)
                        stack_answers = {stack_answers, rejection()};
                    else
                    begin
                        // block order keeps the sequence, one at a time reverses it
                        for (k = 0; k < n; k++)
                            pile_bytes[it.to_stack][hd + k] =
                                pile_bytes[it.from_stack][order_kept ? hs - n + k : hs - 1 - k];
                        pile_height[it.from_stack] = hs - n;
                        pile_height[it.to_stack]   = hd + n;
                    end
                end
            end
            KIND_REPORT:
            begin
                for (k = 0; k < REPORT_COUNT; k++)
                begin
                    hs = pile_height[k];
                    r.result_kind = RES_TOP;
                    r.stack_index = STACK_W'(k);
                    r.top_value   = (hs != 0) ? pile_bytes[k][hs - 1] : '0;
                    r.is_empty    = (hs == 0);
                    r.last        = (k == REPORT_COUNT - 1);
                    stack_answers = {stack_answers, r};
                end
            end
            default: ;
        endcase
    endtask

    // Offers one item, waits for the transfer, then records what should come back
    task automatic send_item(input item_t it, input row_check_t chk);
        int      k;
        result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        apply_to_stacks(it);
        case (chk)
            CHECK_MODEL:
                foreach (stack_answers[j])
                    pending_results = {pending_results, stack_answers[j]};
            CHECK_REJECT:
                pending_results = {pending_results, rejection()};
            CHECK_ALL_EMPTY:
            begin
                for (k = 0; k < REPORT_COUNT; k++)
                begin
                    r.result_kind = RES_TOP;
                    r.stack_index = STACK_W'(k);
                    r.top_value   = '0;
                    r.is_empty    = 1'b1;
                    r.last        = (k == REPORT_COUNT - 1);
                    pending_results = {pending_results, r};
                end
            end
            default: ;
        endcase
        case (it.kind)
            KIND_PUSH:   pushes_sent++;
            KIND_MOVE:   moves_sent++;
            KIND_REPORT: reports_sent++;
            default:     spares_sent++;
        endcase
    endtask

    // Mostly a few busy stacks, so heights build up
    function automatic logic [STACK_W-1:0] pick_stack();
        if ($urandom_range(9) < 7)
            return STACK_W'($urandom_range(3));
        return STACK_W'($urandom_range(15));
    endfunction

    function automatic item_t random_bits();
        logic [31:0] raw;
        raw = $urandom;
        return raw[$bits(item_t)-1:0];
    endfunction

    function automatic item_t random_item(input int pick);
        item_t              it;
        logic [STACK_W-1:0] src;
        logic [STACK_W-1:0] dst;
        int                 room;
        int                 lim;
        int                 tries;
        it = random_bits();
        if (pick < 80)
        begin
            it.kind       = KIND_PUSH;
            it.push_stack = pick_stack();
        end
        else if (pick < 140)
        begin
            // legal move; falls back to a push if none is found
            it.kind       = KIND_PUSH;
            it.push_stack = pick_stack();
            for (tries = 0; tries < 8; tries++)
            begin
                src  = pick_stack();
                dst  = pick_stack();
                room = STACK_DEPTH - pile_height[dst];
                if (src != dst && pile_height[src] > 0 && room > 0)
                begin
                    lim           = (pile_height[src] < room) ? pile_height[src] : room;
                    it.kind       = KIND_MOVE;
                    it.from_stack = src;
                    it.to_stack   = dst;
                    it.move_count = COUNT_W'($urandom_range(lim, 1));
                    break;
                end
            end
        end
        else if (pick < 160)
            it.kind = KIND_MOVE;
        else if (pick < 170)
        begin
            // same stack, count around the height
            src           = pick_stack();
            it.kind       = KIND_MOVE;
            it.from_stack = src;
            it.to_stack   = src;
            it.move_count = COUNT_W'($urandom_range(pile_height[src] + 1, 0));
        end
        else if (pick < 194)
            it.kind = KIND_REPORT;
        else
            it.kind = KIND_SPARE;
        return it;
    endfunction

    // Fill one stack, push once too many, overfill it by a move, then move it all away
    task automatic fill_stack_burst(inout int sent);
        item_t              it;
        logic [STACK_W-1:0] tgt;
        int                 k;
        tgt = pick_stack();
        while (pile_height[tgt] < STACK_DEPTH)
        begin
            it            = random_bits();
            it.kind       = KIND_PUSH;
            it.push_stack = tgt;
            send_item(it, CHECK_MODEL);
            sent++;
        end
        it            = random_bits();
        it.kind       = KIND_PUSH;
        it.push_stack = tgt;
        send_item(it, CHECK_REJECT);
        sent++;
        for (k = 0; k < NUM_STACKS; k++)
        begin
            if (k != tgt && pile_height[k] > 0)
            begin
                it            = random_bits();
                it.kind       = KIND_MOVE;
                it.from_stack = STACK_W'(k);
                it.to_stack   = tgt;
                it.move_count = COUNT_W'($urandom_range(pile_height[k], 1));
                send_item(it, CHECK_REJECT);
                sent++;
                break;
            end
        end
        for (k = 0; k < NUM_STACKS; k++)
        begin
            if (k != tgt && pile_height[k] == 0)
            begin
                it            = random_bits();
                it.kind       = KIND_MOVE;
                it.from_stack = tgt;
                it.to_stack   = STACK_W'(k);
                it.move_count = COUNT_W'(STACK_DEPTH);
                send_item(it, CHECK_MODEL);
                sent++;
                break;
            end
        end
    endtask

    task automatic run_random_phase(input int n_items, input bit with_fill);
        int sent;
        int pick;
        sent = 0;
        if (with_fill)
            fill_stack_burst(sent);
        while (sent < n_items)
        begin
            pick = $urandom_range(199);
            if (pick < 2)
                fill_stack_burst(sent);
            else
            begin
                send_item(random_item(pick), CHECK_MODEL);
                sent++;
            end
        end
        item_valid <= 1'b0;
    endtask

    // Wait for every expected result, then for any silent work still queued
    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic read_keep_order(input logic want);
        logic [PDATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= REG_KEEP_ORDER;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== {{(PDATA_W-1){1'b0}}, want})
        begin
            $display("%0t: keep_order read expected %0h, got %0h", $time, want, got);
            mismatch_count++;
        end
    endtask

    task automatic write_keep_order(input logic v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_KEEP_ORDER;
        pwdata  <= {{(PDATA_W-1){1'b0}}, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        order_kept = v;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        read_keep_order(v);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Result checker: each transfer against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_checked++;
            if (result.result_kind === RES_ERROR)
                rejects_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result transfer with none expected, expected nothing, got %0h",
                         $time, result);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("result_kind", 32'(want.result_kind), 32'(result.result_kind));
                check_field("stack_index", 32'(want.stack_index), 32'(result.stack_index));
                check_field("top_value",   32'(want.top_value),   32'(result.top_value));
                check_field("is_empty",    32'(want.is_empty),    32'(result.is_empty));
                check_field("last",        32'(want.last),        32'(result.last));
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int holds_done;
        int hold_left;
        holds_done   = 0;
        hold_left    = 0;
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Main sequence
    initial
    begin
        int i;
        item_valid      = 1'b0;
        item            = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        rst_n           = 1'b0;
        order_kept      = 1'b0;
        hold_requests   = 0;
        mismatch_count  = 0;
        cycle_count     = 0;
        results_checked = 0;
        rejects_seen    = 0;
        pushes_sent     = 0;
        moves_sent      = 0;
        reports_sent    = 0;
        spares_sent     = 0;
        send_idle_pct   = 36;
        recv_idle_pct   = 63;
        for (i = 0; i < NUM_STACKS; i++)
            pile_height[i] = 0;

        // kind, push_stack, push_value, move_count, from_stack, to_stack, check
        directed_rows[0]  = {KIND_REPORT, 4'd0,  8'h00, 7'd0,   4'd0,  4'd0,  CHECK_ALL_EMPTY};
        directed_rows[1]  = {KIND_PUSH,   4'd0,  8'h00, 7'd0,   4'd0,  4'd0,  CHECK_SILENT};
        directed_rows[2]  = {KIND_PUSH,   4'd0,  8'hFF, 7'd0,   4'd0,  4'd0,  CHECK_SILENT};
        directed_rows[3]  = {KIND_PUSH,   4'd0,  8'h5A, 7'd0,   4'd0,  4'd0,  CHECK_SILENT};
        directed_rows[4]  = {KIND_PUSH,   4'd15, 8'hFF, 7'd0,   4'd0,  4'd0,  CHECK_SILENT};
        directed_rows[5]  = {KIND_PUSH,   4'd7,  8'h81, 7'd0,   4'd0,  4'd0,  CHECK_SILENT};
        directed_rows[6]  = {KIND_REPORT, 4'd0,  8'h00, 7'd0,   4'd0,  4'd0,  CHECK_MODEL};
        // count zero
        directed_rows[7]  = {KIND_MOVE,   4'd0,  8'h00, 7'd0,   4'd0,  4'd1,  CHECK_SILENT};
        // same stack with enough values, then one short
        directed_rows[8]  = {KIND_MOVE,   4'd0,  8'h00, 7'd3,   4'd0,  4'd0,  CHECK_SILENT};
        directed_rows[9]  = {KIND_MOVE,   4'd0,  8'h00, 7'd4,   4'd0,  4'd0,  CHECK_REJECT};
        // source underflow
        directed_rows[10] = {KIND_MOVE,   4'd0,  8'h00, 7'd4,   4'd0,  4'd1,  CHECK_REJECT};
        directed_rows[11] = {KIND_MOVE,   4'd0,  8'h00, 7'h7F,  4'd15, 4'd0,  CHECK_REJECT};
        directed_rows[12] = {KIND_MOVE,   4'd0,  8'h00, 7'd64,  4'd1,  4'd2,  CHECK_REJECT};
        // spare kind is ignored
        directed_rows[13] = {KIND_SPARE,  4'hF,  8'hFF, 7'h7F,  4'hF,  4'hF,  CHECK_SILENT};
        directed_rows[14] = {KIND_MOVE,   4'd0,  8'h00, 7'd2,   4'd0,  4'd1,  CHECK_SILENT};
        directed_rows[15] = {KIND_MOVE,   4'd0,  8'h00, 7'd1,   4'd15, 4'd1,  CHECK_SILENT};
        directed_rows[16] = {KIND_REPORT, 4'd0,  8'h00, 7'd0,   4'd0,  4'd0,  CHECK_MODEL};
        directed_rows[17] = {KIND_PUSH,   4'hF,  8'hFF, 7'h7F,  4'hF,  4'hF,  CHECK_SILENT};
        directed_rows[18] = {KIND_MOVE,   4'd0,  8'h00, 7'd3,   4'd1,  4'd15, CHECK_SILENT};
        directed_rows[19] = {KIND_REPORT, 4'hF,  8'hFF, 7'h7F,  4'hF,  4'hF,  CHECK_MODEL};
        directed_rows[20] = {KIND_MOVE,   4'hF,  8'hFF, 7'd2,   4'd15, 4'd0,  CHECK_MODEL};
        directed_rows[21] = {KIND_REPORT, 4'd0,  8'h00, 7'd0,   4'd0,  4'd0,  CHECK_MODEL};
        directed_rows[22] = {KIND_SPARE,  4'd0,  8'h00, 7'd0,   4'd0,  4'd0,  CHECK_SILENT};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        read_keep_order(1'b0);

        // Directed table, one-at-a-time order
        for (i = 0; i < DIR_ROWS; i++)
            send_item(directed_rows[i].it, directed_rows[i].chk);
        item_valid <= 1'b0;
        wait_drained();

        // Block order, sender idles less than receiver
        write_keep_order(1'b1);
        run_random_phase(PHASE_ITEMS, 1'b1);
        wait_drained();

        // One-at-a-time order, roles swapped
        write_keep_order(1'b0);
        send_idle_pct = 63;
        recv_idle_pct = 36;
        run_random_phase(PHASE_ITEMS, 1'b1);
        wait_drained();

        // Block order, no idling, with a long receiver hold-off at the start
        write_keep_order(1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        run_random_phase(PHASE_ITEMS, 1'b0);
        wait_drained();

        $display("Run covered %0d input transfers: %0d pushes, %0d moves, %0d reports, %0d spare.",
                 pushes_sent + moves_sent + reports_sent + spares_sent,
                 pushes_sent, moves_sent, reports_sent, spares_sent);
        $display("%0d result transfers checked (%0d rejections) over both move orders.",
                 results_checked, rejects_seen);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
